>>> rtl/lbd_pkg.sv
// shared types, constants and helpers for the list-mode buffer deframer
// no dependencies; imported by every module of the block

package lbd_pkg;

   // stream widths
   localparam int DATA_W  = 8;
   localparam int VALUE_W = 48;
   localparam int LEN_W   = 16;
   localparam int EVT_W   = 15;
   localparam int CNT_W   = 5;
   localparam int LINE_W  = 2;

   // framing constants
   localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [LINE_W-1:0] HEADER_LINES = 2'd2;
   localparam logic [LEN_W-1:0]  FILLER_MARK  = 16'hFFFF;
   localparam logic [LEN_W-1:0]  EVENT_BASE   = 16'd21;
   localparam logic [CNT_W:0]    SEP_BYTES    = 6'd8;
   localparam logic [CNT_W:0]    FILLER_BYTES = 6'd7;
   localparam logic [CNT_W:0]    HEAD_BYTES   = 6'd10;
   localparam logic [CNT_W:0]    PARAM_BYTES  = 6'd24;
   localparam logic [CNT_W-1:0]  GATHER_LAST  = 5'd5;

   // reciprocal of 3 with 17 fractional bits, exact for any 16-bit dividend
   localparam logic [16:0] RECIP3 = 17'd43691;

   // parser phases
   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_SEP0   = 4'd1,
      PH_LEN_HI = 4'd2,
      PH_LEN_LO = 4'd3,
      PH_FILLER = 4'd4,
      PH_SKIP10 = 4'd5,
      PH_STAMP  = 4'd6,
      PH_PARAMS = 4'd7,
      PH_EVENT  = 4'd8,
      PH_SEP1   = 4'd9
   } lbd_phase_type;

   // item kinds
   localparam logic KIND_STAMP = 1'b0;
   localparam logic KIND_EVENT = 1'b1;

   // one result item
   typedef struct packed {
      logic               kind;
      logic [VALUE_W-1:0] value;
   } lbd_result_type;

   // result handed from parser to output buffer
   typedef struct packed {
      logic           valid;
      lbd_result_type item;
   } lbd_push_type;

   // number of events in a data buffer: (len - 21) / 3, none below 21
   function automatic logic [EVT_W-1:0] event_count(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0]  diff;
      logic [LEN_W+16:0] prod;
      diff = len - EVENT_BASE;
      prod = {17'd0, diff} * {16'd0, RECIP3};
      if (len < EVENT_BASE) begin
         return '0;
      end
      return prod[31:17];
   endfunction

endpackage

>>> rtl/lbd_parser.sv
// byte parser: phase sequencer, counters and 48-bit value assembly
// depends on lbd_pkg

module lbd_parser
   import lbd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_accept,
   input  logic [DATA_W-1:0]   byte_data,
   output lbd_push_type        push
);

   lbd_phase_type      phase_ff,  phase_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [LINE_W-1:0]  lines_ff,  lines_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [EVT_W-1:0]   events_ff, events_in;
   logic [VALUE_W-1:0] value_ff,  value_in;

   logic               skip_done;
   logic [CNT_W:0]     skip_limit;
   logic [VALUE_W-1:0] gather_value;
   logic               gather_done;
   logic [LINE_W-1:0]  lines_next;
   logic [LEN_W-1:0]   length_lo;
   logic [EVT_W-1:0]   events_new;

   // skip counter limit for the current phase
   always_comb begin
      unique case (phase_ff)
         PH_SEP0, PH_SEP1: skip_limit = SEP_BYTES;
         PH_FILLER:        skip_limit = FILLER_BYTES;
         PH_SKIP10:        skip_limit = HEAD_BYTES;
         PH_PARAMS:        skip_limit = PARAM_BYTES;
         default:          skip_limit = SEP_BYTES;
      endcase
   end

   assign skip_done = ({1'b0, count_ff} + 6'd1) >= skip_limit;

   // place the byte into the value being gathered; words are big-endian, low word first
   always_comb begin
      gather_value = (count_ff == '0) ? '0 : value_ff;
      unique case (count_ff[2:0])
         3'd0:    gather_value[15:8]  = byte_data;
         3'd1:    gather_value[7:0]   = byte_data;
         3'd2:    gather_value[31:24] = byte_data;
         3'd3:    gather_value[23:16] = byte_data;
         3'd4:    gather_value[47:40] = byte_data;
         3'd5:    gather_value[39:32] = byte_data;
         default: gather_value = gather_value;
      endcase
   end

   assign gather_done = count_ff >= GATHER_LAST;
   assign lines_next  = lines_ff + 2'd1;
   assign length_lo   = {length_ff[15:8], byte_data};
   assign events_new  = event_count(length_ff);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      lines_in  = lines_ff;
      length_in = length_ff;
      events_in = events_ff;
      value_in  = value_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (byte_data == NEWLINE_BYTE) begin
                  lines_in = lines_next;
                  if (lines_next >= HEADER_LINES) begin
                     phase_in = PH_SEP0;
                     count_in = '0;
                  end
               end
            end
            PH_SEP0, PH_SEP1, PH_FILLER: begin
               count_in = skip_done ? '0 : count_ff + 5'd1;
               if (skip_done) begin
                  phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_LO: begin
               length_in = length_lo;
               count_in  = '0;
               phase_in  = (length_lo == FILLER_MARK) ? PH_FILLER : PH_SKIP10;
            end
            PH_SKIP10: begin
               count_in = skip_done ? '0 : count_ff + 5'd1;
               if (skip_done) begin
                  phase_in = PH_STAMP;
               end
            end
            PH_STAMP: begin
               value_in = gather_value;
               count_in = gather_done ? '0 : count_ff + 5'd1;
               if (gather_done) begin
                  phase_in = PH_PARAMS;
               end
            end
            PH_PARAMS: begin
               count_in = skip_done ? '0 : count_ff + 5'd1;
               if (skip_done) begin
                  events_in = events_new;
                  phase_in  = (events_new != '0) ? PH_EVENT : PH_SEP1;
               end
            end
            PH_EVENT: begin
               value_in = gather_value;
               count_in = gather_done ? '0 : count_ff + 5'd1;
               if (gather_done) begin
                  if (events_ff != '0) begin
                     events_in = events_ff - 15'd1;
                  end
                  if (events_ff <= 15'd1) begin
                     phase_in = PH_SEP1;
                  end
               end
            end
            default: begin
               // length high byte, also taken by any unused phase code
               length_in = {byte_data, 8'h00};
               count_in  = '0;
               phase_in  = PH_LEN_LO;
            end
         endcase
      end
   end

   // result output
   always_comb begin
      push.valid      = 1'b0;
      push.item.kind  = KIND_STAMP;
      push.item.value = gather_value;
      if (byte_accept && gather_done) begin
         unique case (phase_ff)
            PH_STAMP: begin
               push.valid     = 1'b1;
               push.item.kind = KIND_STAMP;
            end
            PH_EVENT: begin
               push.valid     = 1'b1;
               push.item.kind = KIND_EVENT;
            end
            default: begin
               push.valid = 1'b0;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         count_ff  <= '0;
         lines_ff  <= '0;
         length_ff <= '0;
         events_ff <= '0;
         value_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         lines_ff  <= lines_in;
         length_ff <= length_in;
         events_ff <= events_in;
         value_ff  <= value_in;
      end
   end

endmodule

>>> rtl/lbd_rsp_buffer.sv
// two-entry output buffer: result register plus skid register
// depends on lbd_pkg

module lbd_rsp_buffer
   import lbd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  lbd_push_type   push,
   output logic           space,
   output logic           out_valid,
   input  logic           out_ready,
   output lbd_result_type out_item
);

   logic           main_valid_ff, main_valid_in;
   lbd_result_type main_item_ff,  main_item_in;
   logic           skid_valid_ff, skid_valid_in;
   lbd_result_type skid_item_ff,  skid_item_in;
   logic           pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_item_ff;

   // refill the result register from skid first, then from the parser
   always_comb begin
      main_valid_in = main_valid_ff;
      main_item_in  = main_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_item_in  = skid_item_ff;
            skid_valid_in = push.valid;
            skid_item_in  = push.item;
         end else begin
            main_valid_in = push.valid;
            main_item_in  = push.item;
         end
      end else if (push.valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

>>> rtl/listmode_buffer_deframer_core.sv
// top level of the list-mode buffer deframer
// depends on lbd_pkg, lbd_parser and lbd_rsp_buffer
//
//  channel | direction | tdata             | tuser
//  req     | in        | [7:0] data_byte   | -
//  rsp     | out       | [47:0] item_value | [0] item_kind
//
// one byte is taken per cycle, back to back, while req_tready is high; the byte that
// completes a value loads the rsp register, or the skid entry if it is held, at its own
// transfer edge; the throughput limit is the single phase/counter update per byte
// synchronous reset returns the parser to header skipping and empties the outputs
// a stalled rsp side is absorbed by a skid entry; req_tready drops only when
// both output entries are full

module listmode_buffer_deframer_core
   import lbd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [DATA_W-1:0]  req_tdata,   // [7:0] data_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [VALUE_W-1:0] rsp_tdata,   // [47:0] item_value
   output logic               rsp_tuser    // [0] item_kind
);

   logic           byte_accept;
   lbd_push_type   push;
   logic           space;
   lbd_result_type out_item;

   assign req_tready  = space;
   assign byte_accept = req_tvalid && space;

   lbd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .byte_data   (req_tdata),
      .push        (push)
   );

   lbd_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item.value;
   assign rsp_tuser = out_item.kind;

endmodule

>>> rtl/lbd_checker.sv
// port-level checks for the list-mode buffer deframer, bound to the top level
// depends on lbd_pkg

module lbd_checker
   import lbd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [VALUE_W-1:0] rsp_tdata,
   input logic               rsp_tuser
);

   // reset empties the outputs and opens the input
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not cleared by reset");

   // input back-pressure only while a result is pending
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // a new result follows a byte transfer
   a_result_needs_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(req_tvalid && req_tready))
      else $error("result appeared without a byte transfer");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind listmode_buffer_deframer_core lbd_checker u_lbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
